// File: rtl/core/assert_macros.svh
// Assertion helper macros for the LED slot engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

// File: rtl/core/lbse_pkg.sv
// ----------------------------------------------------------------------------
// lbse_pkg
// Types and constants shared by the LED effect slot engine.
// ----------------------------------------------------------------------------
package lbse_pkg;

  localparam logic [7:0] NoLed        = 8'd255;
  localparam logic [7:0] ForeverCount = 8'd255;
  localparam int unsigned MaxResults  = 8;

  typedef enum logic [2:0] {
    KindTick    = 3'd0,
    KindBlink   = 3'd1,
    KindBreathe = 3'd2,
    KindClear   = 3'd3,
    KindRelease = 3'd4,
    KindOnOne   = 3'd5,
    KindOnAll   = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    RegEnabled  = 3'd0,
    RegOnLevel  = 3'd1,
    RegDimTop   = 3'd2,
    RegGroupOne = 3'd3,
    RegGroupTwo = 3'd4
  } reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StClear,   // scan for slot owning code
    StFree,    // scan for free slot
    StTick,    // step each slot in turn
    StRelease,
    StDone
  } state_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] led_code;
    logic [7:0] on_ticks;
    logic [7:0] off_ticks;
    logic [7:0] repeat_count;
    logic [7:0] step_ticks;
    logic       key_hold;
    logic       turn_on;
  } in_item_t;

  typedef struct packed {
    logic [7:0] target;
    logic [7:0] level;
    logic       all_channels;
    logic       table_full;
    logic       last;
  } out_item_t;

endpackage

// File: rtl/core/lbse_out_fifo.sv
// ----------------------------------------------------------------------------
// lbse_out_fifo
// Small result queue; the sequencer pushes writes, the last flag is set on
// the final beat when the item closes.
// ----------------------------------------------------------------------------
module lbse_out_fifo #(
  parameter int unsigned Depth = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lbse_pkg::out_item_t push_data_i,
  input  logic                mark_last_i,
  output logic                empty_o,
  output logic                valid_o,
  input  logic                ready_i,
  output lbse_pkg::out_item_t data_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  lbse_pkg::out_item_t mem_q [Depth];
  logic [Aw-1:0] wr_q, rd_q, last_idx;
  logic [Aw:0]   cnt_q;
  logic          pop;

  assign pop      = valid_o && ready_i;
  assign valid_o  = (cnt_q != '0);
  assign empty_o  = (cnt_q == '0);
  assign data_o   = mem_q[rd_q];
  assign last_idx = (wr_q == '0) ? Aw'(Depth - 1) : wr_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
    if (mark_last_i) mem_q[last_idx].last <= 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)    rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(pop);
    end
  end
endmodule

// File: rtl/core/led_blink_breathe_slot_engine.sv
// A start runs the owner scan, then the free-slot scan, then the close; tick, clear,
// release and on_off one run a single slot scan and then the close.
// Results are presented only once the item has closed.
// Throughput: one item at a time; the next is taken once the result queue
// has drained, so a stalled output holds off the input.
// Reset: async active low; all slots free, registers at their reset values.
// ----------------------------------------------------------------------------
// led_blink_breathe_slot_engine
// Effect slot table with a sequencer that walks the slots one per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module led_blink_breathe_slot_engine #(
  parameter int unsigned SLOTS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lbse_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lbse_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  localparam int unsigned Sw = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // config
  logic       enabled_q;
  logic [7:0] on_level_q, dim_top_q, grp1_q, grp2_q;

  // slot table
  logic [7:0] s_led_q [SLOTS];
  logic       s_br_q [SLOTS], s_rise_q [SLOTS], s_hold_q [SLOTS], s_rel_q [SLOTS];
  logic [7:0] s_step_q [SLOTS], s_tmr_q [SLOTS], s_on_q [SLOTS], s_off_q [SLOTS];
  logic [7:0] s_cnt_q [SLOTS];

  lbse_pkg::state_e   st_q, st_d;
  lbse_pkg::in_item_t it_q;
  logic [Sw-1:0]      idx_q, idx_d;
  logic [3:0]         nres_q, nres_d;
  logic               found_q, found_d;

  logic                push, fifo_empty, mark_last;
  logic                fifo_valid, seq_idle;
  lbse_pkg::out_item_t pdata;
  logic [7:0]          wcode, wlvl;
  logic                wreq, wall, wfull;
  logic                idx_end;

  assign cfg_ready_o = 1'b1;
  assign seq_idle    = (st_q == lbse_pkg::StIdle);
  assign in_ready_o  = seq_idle && fifo_empty;
  assign idx_end     = (idx_q == Sw'(SLOTS - 1));
  // beats are held back until the item closes so the last flag is in place
  assign out_valid_o = fifo_valid && seq_idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0; on_level_q <= 8'd5; dim_top_q <= 8'd32;
      grp1_q <= 8'd64; grp2_q <= 8'd65;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lbse_pkg::RegEnabled:  enabled_q  <= cfg_data_i[0];
        lbse_pkg::RegOnLevel:  on_level_q <= cfg_data_i;
        lbse_pkg::RegDimTop:   dim_top_q  <= cfg_data_i;
        lbse_pkg::RegGroupOne: grp1_q     <= cfg_data_i;
        lbse_pkg::RegGroupTwo: grp2_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // current slot view
  logic [7:0] c_led, c_step, c_tmr, c_on, c_off, c_cnt, c_cnt_m1;
  logic       c_br, c_rise, c_hold, c_rel, c_free;
  assign c_led  = s_led_q[idx_q];  assign c_step = s_step_q[idx_q];
  assign c_tmr  = s_tmr_q[idx_q];  assign c_on   = s_on_q[idx_q];
  assign c_off  = s_off_q[idx_q];  assign c_cnt  = s_cnt_q[idx_q];
  assign c_br   = s_br_q[idx_q];   assign c_rise = s_rise_q[idx_q];
  assign c_hold = s_hold_q[idx_q]; assign c_rel  = s_rel_q[idx_q];
  assign c_free = (c_led == lbse_pkg::NoLed);
  assign c_cnt_m1 = c_cnt - 8'd1;

  // slot update from the sequencer (tick step, clear and start)
  logic       u_we, u_free, u_rise, u_rel_set, u_start;
  logic [7:0] u_step, u_tmr, u_cnt;

  always_comb begin
    st_d = st_q; idx_d = idx_q; nres_d = nres_q; found_d = found_q;
    wreq = 1'b0; wcode = c_led; wlvl = 8'd0; wall = 1'b0; wfull = 1'b0;
    mark_last = 1'b0;
    u_we = 1'b0; u_free = 1'b0; u_rise = c_rise; u_step = c_step;
    u_tmr = c_tmr; u_cnt = c_cnt; u_rel_set = 1'b0; u_start = 1'b0;
    case (st_q)
      lbse_pkg::StIdle: begin
        if (in_valid_i && in_ready_o) begin
          idx_d = '0; nres_d = '0; found_d = 1'b0;
          st_d = lbse_pkg::StDone;
          if (enabled_q) begin
            case (in_data_i.kind)
              lbse_pkg::KindTick:    st_d = lbse_pkg::StTick;
              lbse_pkg::KindBlink:
                if (in_data_i.led_code != lbse_pkg::NoLed &&
                    in_data_i.on_ticks != 8'd0 && in_data_i.off_ticks != 8'd0)
                  st_d = lbse_pkg::StClear;
              lbse_pkg::KindBreathe:
                if (in_data_i.led_code != lbse_pkg::NoLed &&
                    in_data_i.step_ticks >= dim_top_q)
                  st_d = lbse_pkg::StClear;
              lbse_pkg::KindClear, lbse_pkg::KindOnOne:
                if (in_data_i.led_code != lbse_pkg::NoLed) st_d = lbse_pkg::StClear;
              lbse_pkg::KindRelease: st_d = lbse_pkg::StRelease;
              lbse_pkg::KindOnAll:   st_d = lbse_pkg::StDone;
              default: ;
            endcase
          end
        end
      end
      lbse_pkg::StClear: begin
        if (c_led == it_q.led_code) begin
          wreq = 1'b1; wlvl = 8'd0; u_we = 1'b1; u_free = 1'b1;
          found_d = 1'b1;
        end
        if (c_led == it_q.led_code || idx_end) begin
          idx_d = '0;
          if (it_q.kind == lbse_pkg::KindBlink || it_q.kind == lbse_pkg::KindBreathe)
            st_d = lbse_pkg::StFree;
          else if (it_q.kind == lbse_pkg::KindOnOne && c_led != it_q.led_code) begin
            wreq = 1'b1; wcode = it_q.led_code;
            wlvl = it_q.turn_on ? on_level_q : 8'd0;
            st_d = lbse_pkg::StDone;
          end else st_d = lbse_pkg::StDone;
        end else idx_d = idx_q + 1'b1;
      end
      lbse_pkg::StFree: begin
        // a slot freed in StClear reads free here by the next cycle
        if (c_free) begin
          u_start = 1'b1;
          if (it_q.kind == lbse_pkg::KindBlink) begin
            wreq = 1'b1; wcode = it_q.led_code; wlvl = on_level_q;
          end
          st_d = lbse_pkg::StDone;
        end else if (idx_end) begin
          wreq = 1'b1; wcode = it_q.led_code; wfull = 1'b1;
          st_d = lbse_pkg::StDone;
        end else idx_d = idx_q + 1'b1;
      end
      lbse_pkg::StRelease: begin
        if (c_br && c_led == it_q.led_code) u_rel_set = 1'b1;
        if (idx_end) st_d = lbse_pkg::StDone; else idx_d = idx_q + 1'b1;
      end
      lbse_pkg::StTick: begin
        if (!c_free) begin
          u_we = 1'b1;
          if (!c_br) begin
            if (c_tmr != 8'd0) u_tmr = c_tmr - 8'd1;
            else begin
              u_rise = !c_rise;
              u_tmr  = !c_rise ? c_on : c_off;
              u_step = !c_rise ? on_level_q : 8'd0;
              wreq = 1'b1; wlvl = u_step;
              if (c_cnt != lbse_pkg::ForeverCount && c_rise) begin
                u_cnt = c_cnt_m1;
                if (c_cnt_m1 == 8'd0) begin u_free = 1'b1; wlvl = 8'd0; end
              end
            end
          end else begin
            if (c_tmr < c_on) u_tmr = c_tmr + 8'd1;
            else begin
              u_tmr = 8'd0;
              wreq = 1'b1;
              if (c_rise) begin
                if (c_step < dim_top_q) u_step = c_step + 8'd1;
                else if (c_hold && !c_rel) wreq = 1'b0;
                else u_rise = 1'b0;
              end else if (c_step != 8'd0) u_step = c_step - 8'd1;
              else begin
                if (c_cnt != lbse_pkg::ForeverCount) u_cnt = c_cnt_m1;
                if ((c_cnt != lbse_pkg::ForeverCount && c_cnt_m1 == 8'd0) || c_hold)
                  u_free = 1'b1;
                else u_rise = 1'b1;
              end
              wlvl = u_free ? 8'd0 : u_step;
            end
          end
        end
        if (idx_end) st_d = lbse_pkg::StDone; else idx_d = idx_q + 1'b1;
      end
      lbse_pkg::StDone: begin
        if (it_q.kind == lbse_pkg::KindOnAll && enabled_q && nres_q == '0) begin
          wreq = 1'b1; wcode = 8'd0; wall = 1'b1;
          wlvl = it_q.turn_on ? on_level_q : 8'd0;
          nres_d = 4'd1;
        end else begin
          mark_last = (nres_q != '0);
          st_d = lbse_pkg::StIdle;
        end
      end
      default: st_d = lbse_pkg::StIdle;
    endcase
  end

  // code filter: only single LEDs, the two groups, all-channel and table-full results are written
  logic code_ok;
  assign code_ok = wall || wfull ||
                   (wcode != lbse_pkg::NoLed &&
                    (wcode <= grp1_q || wcode == grp2_q));
  assign push  = wreq && code_ok && (nres_q < 4'(lbse_pkg::MaxResults));
  assign pdata = '{target: wcode, level: wfull ? 8'd0 : wlvl,
                   all_channels: wall, table_full: wfull, last: 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= lbse_pkg::StIdle; idx_q <= '0; nres_q <= '0; found_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; found_q <= found_d;
      nres_q <= (st_q == lbse_pkg::StIdle) ? nres_d : nres_d + 4'(push);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) it_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        s_led_q[i] <= lbse_pkg::NoLed; s_br_q[i] <= 1'b0; s_rise_q[i] <= 1'b0;
        s_step_q[i] <= 8'd0; s_tmr_q[i] <= 8'd0; s_hold_q[i] <= 1'b0;
        s_rel_q[i] <= 1'b0;
      end
    end else begin
      if (st_q == lbse_pkg::StDone && it_q.kind == lbse_pkg::KindOnAll &&
          enabled_q && nres_q == '0) begin
        for (int i = 0; i < SLOTS; i++) s_led_q[i] <= lbse_pkg::NoLed;
      end
      if (u_rel_set) s_rel_q[idx_q] <= 1'b1;
      if (u_we) begin
        s_rise_q[idx_q] <= u_rise; s_step_q[idx_q] <= u_step;
        s_tmr_q[idx_q] <= u_tmr;
        if (u_free) s_led_q[idx_q] <= lbse_pkg::NoLed;
      end
      if (u_start) begin
        s_led_q[idx_q]  <= it_q.led_code;
        s_br_q[idx_q]   <= (it_q.kind == lbse_pkg::KindBreathe);
        s_rise_q[idx_q] <= 1'b1;
        s_rel_q[idx_q]  <= 1'b0;
        if (it_q.kind == lbse_pkg::KindBlink) begin
          s_step_q[idx_q] <= on_level_q; s_tmr_q[idx_q] <= it_q.on_ticks;
          s_hold_q[idx_q] <= 1'b0;
        end else begin
          s_step_q[idx_q] <= 8'd0; s_tmr_q[idx_q] <= 8'd0;
          s_hold_q[idx_q] <= it_q.key_hold;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (u_we) s_cnt_q[idx_q] <= u_cnt;
    if (u_start) begin
      s_cnt_q[idx_q] <= it_q.repeat_count;
      s_on_q[idx_q]  <= (it_q.kind == lbse_pkg::KindBlink) ? it_q.on_ticks
                                                           : it_q.step_ticks;
      s_off_q[idx_q] <= it_q.off_ticks;
    end
  end

  lbse_out_fifo #(.Depth(lbse_pkg::MaxResults)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(pdata), .mark_last_i(mark_last),
    .empty_o(fifo_empty), .valid_o(fifo_valid), .ready_i(out_ready_i && seq_idle),
    .data_o(out_data_o)
  );

  `ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni,
    in_valid_i && in_ready_o && !fifo_empty, "input taken with results pending")
  `ASSERT_IMPL(a_results_bounded, clk_i, rst_ni,
    nres_q <= 4'(lbse_pkg::MaxResults), "too many results")
  `ASSERT_NEVER(a_full_level, clk_i, rst_ni,
    push && pdata.table_full && pdata.level != 8'd0, "full result with level")
  `ASSERT_IMPL(a_idle_after_done, clk_i, rst_ni,
    (st_q == lbse_pkg::StDone && st_d == lbse_pkg::StIdle) |=> st_q == lbse_pkg::StIdle,
    "sequencer did not return to idle")
endmodule
